// File: hdl/plrp_pkg.sv
// Shared types and constants for the port list range parser.
package plrp_pkg;

   localparam int MAP_WORD_BITS = 32;
   localparam int PORT_W        = 16;
   localparam int VALUE_W       = 17;
   localparam int MAP_WORDS     = (1 << PORT_W) / MAP_WORD_BITS;
   localparam int WORD_AW       = $clog2(MAP_WORDS);
   localparam int BIT_AW        = $clog2(MAP_WORD_BITS);
   localparam int CNT_W         = $clog2(MAP_WORD_BITS + 1);
   localparam int RSP_TDATA_W   = 40;

   localparam logic [VALUE_W-1:0] MAX_PORT  = VALUE_W'(65535);
   localparam logic [VALUE_W-1:0] VALUE_SAT = VALUE_W'(65536);

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      OP_FEED,
      OP_END,
      OP_FETCH,
      OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      PH_START,
      PH_SIGN,
      PH_DIGITS,
      PH_STOP
   } phase_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_FET_RD,
      ST_FET_CHK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              err;
      logic              empty;
      logic [PORT_W-1:0] lo;
      logic [PORT_W-1:0] hi;
   } range_type;

   typedef struct packed {
      phase_type          phase;
      logic [VALUE_W-1:0] val;
      logic               dig;
      logic               neg;
   } part_type;

endpackage

// File: hdl/plrp_parse.sv
// Token parser: character feed, part values and the clamped range of the current token.
module plrp_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                feed_en,
   input  logic [7:0]          ch,
   input  logic                flush,
   output plrp_pkg::range_type rng,
   output logic                token_nonempty
);
   import plrp_pkg::*;

   part_type low_ff, low_in;
   part_type high_ff, high_in;
   logic     dash_ff, dash_in;
   logic     nonempty_ff, nonempty_in;

   logic [VALUE_W-1:0] a_val, b_val, lo_val, hi_val, lo_c, hi_c;

   function automatic part_type part_step(part_type cur, logic [7:0] c, logic allow_minus);
      part_type           nxt;
      logic               is_digit;
      logic               is_space;
      logic               take_digit;
      logic [20:0]        acc;
      begin
         nxt        = cur;
         is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
         is_space   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
         take_digit = 1'b0;
         case (cur.phase)
            PH_START: begin
               if (is_space) begin
                  nxt.phase = PH_START;
               end else if (c == CH_PLUS) begin
                  nxt.phase = PH_SIGN;
               end else if ((c == CH_DASH) && allow_minus) begin
                  nxt.neg   = 1'b1;
                  nxt.phase = PH_SIGN;
               end else begin
                  take_digit = 1'b1;
               end
            end
            PH_SIGN, PH_DIGITS: begin
               take_digit = 1'b1;
            end
            default: begin
               nxt.phase = PH_STOP;
            end
         endcase
         if (take_digit) begin
            if (is_digit) begin
               acc = cur.dig ? (({4'd0, cur.val} << 3) + ({4'd0, cur.val} << 1)) : 21'd0;
               acc = acc + 21'(c - CH_ZERO);
               nxt.val   = (acc > 21'(VALUE_SAT)) ? VALUE_SAT : acc[VALUE_W-1:0];
               nxt.dig   = 1'b1;
               nxt.phase = PH_DIGITS;
            end else begin
               nxt.phase = PH_STOP;
            end
         end
         part_step = nxt;
      end
   endfunction

   always_comb begin
      low_in      = low_ff;
      high_in     = high_ff;
      dash_in     = dash_ff;
      nonempty_in = nonempty_ff;
      if (flush) begin
         low_in      = '{phase: PH_START, val: '0, dig: 1'b0, neg: 1'b0};
         high_in     = '{phase: PH_START, val: '0, dig: 1'b0, neg: 1'b0};
         dash_in     = 1'b0;
         nonempty_in = 1'b0;
      end else if (feed_en) begin
         nonempty_in = 1'b1;
         if (!dash_ff && (ch == CH_DASH)) begin
            dash_in = 1'b1;
         end else if (!dash_ff) begin
            low_in = part_step(low_ff, ch, 1'b0);
         end else begin
            high_in = part_step(high_ff, ch, 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= '{phase: PH_START, val: '0, dig: 1'b0, neg: 1'b0};
         high_ff     <= '{phase: PH_START, val: '0, dig: 1'b0, neg: 1'b0};
         dash_ff     <= 1'b0;
         nonempty_ff <= 1'b0;
      end else begin
         low_ff      <= low_in;
         high_ff     <= high_in;
         dash_ff     <= dash_in;
         nonempty_ff <= nonempty_in;
      end
   end

   always_comb begin
      a_val = low_ff.val;
      b_val = dash_ff ? (high_ff.neg ? '0 : high_ff.val) : low_ff.val;
      lo_val = (a_val < b_val) ? a_val : b_val;
      hi_val = (a_val < b_val) ? b_val : a_val;
      lo_c   = (lo_val == '0) ? VALUE_W'(1) : lo_val;
      hi_c   = (hi_val > MAX_PORT) ? MAX_PORT : hi_val;
      rng.err   = !low_ff.dig || (dash_ff && !high_ff.dig);
      rng.empty = lo_c > hi_c;
      rng.lo    = lo_c[PORT_W-1:0];
      rng.hi    = hi_c[PORT_W-1:0];
   end

   assign token_nonempty = nonempty_ff;

endmodule

// File: hdl/port_list_range_parser_top.sv
// Port list range parser top level: sequencer, port bitmap memory and result register.
// Feed of a character: ready again the next cycle, unless a comma closes a valid range.
// Range insertion: each bitmap word covered is read, then merged and written.
// Fetch: each word is read, then checked, up to the next port and the one after it.
// Result register loads in ST_RESP once the output is free; no result on feed/clear.
// Reset and clear sweep all 2048 bitmap words with req_tready low.
module port_list_range_parser_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // ch
   input  logic [1:0]                            req_tuser,  // op
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [plrp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // port, port_count, parse_error
   output logic                                  rsp_tuser,  // valid_res
   output logic                                  rsp_tlast   // last_port
);
   import plrp_pkg::*;

   localparam logic [MAP_WORD_BITS-1:0] WORD_ONES = '1;
   localparam logic [WORD_AW-1:0]       LAST_W    = '1;
   localparam logic [BIT_AW-1:0]        TOP_BIT   = '1;

   state_type state_ff, state_in;

   logic [MAP_WORD_BITS-1:0] bitmap_mem [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0] rd_data_ff;
   logic                     mem_we;
   logic [MAP_WORD_BITS-1:0] mem_wdata;

   logic [WORD_AW-1:0] cur_w_ff, cur_w_in;
   logic [WORD_AW-1:0] lo_w_ff, lo_w_in;
   logic [WORD_AW-1:0] end_w_ff, end_w_in;
   logic [BIT_AW-1:0]  lo_bit_ff, lo_bit_in;
   logic [BIT_AW-1:0]  hi_bit_ff, hi_bit_in;
   logic               end_pend_ff, end_pend_in;
   logic               fphase_ff, fphase_in;
   logic               ffirst_ff, ffirst_in;
   logic [BIT_AW-1:0]  fstart_ff, fstart_in;
   logic [PORT_W-1:0]  fnd_port_ff, fnd_port_in;
   logic               fnd_valid_ff, fnd_valid_in;
   logic               fnd_last_ff, fnd_last_in;
   logic [VALUE_W-1:0] fetch_ptr_ff, fetch_ptr_in;
   logic [PORT_W-1:0]  count_ff, count_in;
   logic               err_ff, err_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0]  rsp_port_ff, rsp_port_in;
   logic               rsp_vres_ff, rsp_vres_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [PORT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               req_fire;
   op_type             req_op;
   logic               is_comma;
   logic               feed_en;
   logic               flush;
   range_type          rng;
   logic               token_nonempty;
   logic               tok_insert;

   logic [BIT_AW-1:0]        ins_lo_b, ins_hi_b;
   logic [MAP_WORD_BITS-1:0] ins_mask, ins_new;
   logic                     ins_done;

   logic [MAP_WORD_BITS-1:0] hits, above;
   logic [BIT_AW-1:0]        hit_bit;
   logic                     hit_any, above_any, last_w;
   logic                     rsp_load;

   function automatic logic [CNT_W-1:0] popcount(logic [MAP_WORD_BITS-1:0] v);
      logic [CNT_W-1:0] n;
      begin
         n = '0;
         for (int i = 0; i < MAP_WORD_BITS; i++) begin
            n = n + CNT_W'(v[i]);
         end
         popcount = n;
      end
   endfunction

   function automatic logic [BIT_AW-1:0] lowest(logic [MAP_WORD_BITS-1:0] v);
      logic [BIT_AW-1:0] idx;
      begin
         idx = '0;
         for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
               idx = BIT_AW'(i);
            end
         end
         lowest = idx;
      end
   endfunction

   plrp_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .feed_en        (feed_en),
      .ch             (req_tdata),
      .flush          (flush),
      .rng            (rng),
      .token_nonempty (token_nonempty)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign is_comma   = (req_tdata == CH_COMMA);
   assign feed_en    = req_fire && (req_op == OP_FEED) && !is_comma;
   assign flush      = req_fire && ((req_op == OP_CLEAR) || (req_op == OP_END) ||
                                    ((req_op == OP_FEED) && is_comma));
   assign tok_insert = !rng.err && !rng.empty;

   assign ins_lo_b = (cur_w_ff == lo_w_ff) ? lo_bit_ff : '0;
   assign ins_hi_b = (cur_w_ff == end_w_ff) ? hi_bit_ff : TOP_BIT;
   assign ins_mask = (WORD_ONES << ins_lo_b) & (WORD_ONES >> (TOP_BIT - ins_hi_b));
   assign ins_new  = ins_mask & ~rd_data_ff;
   assign ins_done = (cur_w_ff == end_w_ff);

   assign hits      = rd_data_ff & (ffirst_ff ? (WORD_ONES << fstart_ff) : WORD_ONES);
   assign hit_any   = (hits != '0);
   assign hit_bit   = lowest(hits);
   assign above     = rd_data_ff & (WORD_ONES << ((BIT_AW + 1)'(hit_bit) + (BIT_AW + 1)'(1)));
   assign above_any = (above != '0);
   assign last_w    = (cur_w_ff == LAST_W);
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);

   assign mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_INS_WR);
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : (rd_data_ff | ins_mask);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[cur_w_ff] <= mem_wdata;
      end
      rd_data_ff <= bitmap_mem[cur_w_ff];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cur_w_ff == LAST_W) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  OP_FEED: begin
                     if (is_comma && tok_insert) begin
                        state_in = ST_INS_RD;
                     end
                  end
                  OP_END: begin
                     state_in = (token_nonempty && tok_insert) ? ST_INS_RD : ST_RESP;
                  end
                  OP_FETCH: begin
                     state_in = fetch_ptr_ff[PORT_W] ? ST_RESP : ST_FET_RD;
                  end
                  OP_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INS_RD: begin
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            if (ins_done) begin
               state_in = end_pend_ff ? ST_RESP : ST_IDLE;
            end else begin
               state_in = ST_INS_RD;
            end
         end
         ST_FET_RD: begin
            state_in = ST_FET_CHK;
         end
         ST_FET_CHK: begin
            if (!fphase_ff) begin
               if (hit_any) begin
                  state_in = (above_any || last_w) ? ST_RESP : ST_FET_RD;
               end else begin
                  state_in = last_w ? ST_RESP : ST_FET_RD;
               end
            end else begin
               state_in = (hit_any || last_w) ? ST_RESP : ST_FET_RD;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cur_w_in     = cur_w_ff;
      lo_w_in      = lo_w_ff;
      end_w_in     = end_w_ff;
      lo_bit_in    = lo_bit_ff;
      hi_bit_in    = hi_bit_ff;
      end_pend_in  = end_pend_ff;
      fphase_in    = fphase_ff;
      ffirst_in    = ffirst_ff;
      fstart_in    = fstart_ff;
      fnd_port_in  = fnd_port_ff;
      fnd_valid_in = fnd_valid_ff;
      fnd_last_in  = fnd_last_ff;
      fetch_ptr_in = fetch_ptr_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_port_in  = rsp_port_ff;
      rsp_vres_in  = rsp_vres_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cur_w_in = cur_w_ff + WORD_AW'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               cur_w_in    = rng.lo[PORT_W-1:BIT_AW];
               lo_w_in     = rng.lo[PORT_W-1:BIT_AW];
               end_w_in    = rng.hi[PORT_W-1:BIT_AW];
               lo_bit_in   = rng.lo[BIT_AW-1:0];
               hi_bit_in   = rng.hi[BIT_AW-1:0];
               end_pend_in = (req_op == OP_END);
               unique case (req_op)
                  OP_FEED: begin
                     if (is_comma && rng.err) begin
                        err_in = 1'b1;
                     end
                  end
                  OP_END: begin
                     if (token_nonempty && rng.err) begin
                        err_in = 1'b1;
                     end
                     fetch_ptr_in = '0;
                     fnd_port_in  = '0;
                     fnd_valid_in = 1'b0;
                     fnd_last_in  = 1'b0;
                  end
                  OP_FETCH: begin
                     cur_w_in     = fetch_ptr_ff[PORT_W-1:BIT_AW];
                     fstart_in    = fetch_ptr_ff[BIT_AW-1:0];
                     ffirst_in    = 1'b1;
                     fphase_in    = 1'b0;
                     fnd_port_in  = '0;
                     fnd_valid_in = 1'b0;
                     fnd_last_in  = 1'b0;
                  end
                  OP_CLEAR: begin
                     cur_w_in     = '0;
                     count_in     = '0;
                     err_in       = 1'b0;
                     fetch_ptr_in = '0;
                  end
                  default: begin
                     err_in = err_ff;
                  end
               endcase
            end
         end
         ST_INS_WR: begin
            count_in = count_ff + PORT_W'(popcount(ins_new));
            if (!ins_done) begin
               cur_w_in = cur_w_ff + WORD_AW'(1);
            end
         end
         ST_FET_CHK: begin
            if (!fphase_ff) begin
               if (hit_any) begin
                  fnd_port_in  = {cur_w_ff, hit_bit};
                  fnd_valid_in = 1'b1;
                  fetch_ptr_in = {1'b0, cur_w_ff, hit_bit} + VALUE_W'(1);
                  fnd_last_in  = !above_any && last_w;
                  if (!above_any && !last_w) begin
                     fphase_in = 1'b1;
                     ffirst_in = 1'b0;
                     cur_w_in  = cur_w_ff + WORD_AW'(1);
                  end
               end else if (!last_w) begin
                  ffirst_in = 1'b0;
                  cur_w_in  = cur_w_ff + WORD_AW'(1);
               end
            end else begin
               if (hit_any) begin
                  fnd_last_in = 1'b0;
               end else if (last_w) begin
                  fnd_last_in = 1'b1;
               end else begin
                  cur_w_in = cur_w_ff + WORD_AW'(1);
               end
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_port_in  = fnd_port_ff;
               rsp_vres_in  = fnd_valid_ff;
               rsp_last_in  = fnd_last_ff;
               rsp_count_in = count_ff;
               rsp_err_in   = err_ff;
            end
         end
         default: begin
            cur_w_in = cur_w_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_w_ff     <= '0;
         end_pend_ff  <= 1'b0;
         fphase_ff    <= 1'b0;
         ffirst_ff    <= 1'b0;
         fetch_ptr_ff <= '0;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_w_ff     <= cur_w_in;
         end_pend_ff  <= end_pend_in;
         fphase_ff    <= fphase_in;
         ffirst_ff    <= ffirst_in;
         fetch_ptr_ff <= fetch_ptr_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_w_ff      <= lo_w_in;
      end_w_ff     <= end_w_in;
      lo_bit_ff    <= lo_bit_in;
      hi_bit_ff    <= hi_bit_in;
      fstart_ff    <= fstart_in;
      fnd_port_ff  <= fnd_port_in;
      fnd_valid_ff <= fnd_valid_in;
      fnd_last_ff  <= fnd_last_in;
      rsp_port_ff  <= rsp_port_in;
      rsp_vres_ff  <= rsp_vres_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2 * PORT_W - 1){1'b0}}, rsp_err_ff, rsp_count_ff,
                        rsp_port_ff};
   assign rsp_tuser  = rsp_vres_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: tb/port_list_range_parser_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the port list range parser: directed table, then random entries.
module port_list_range_parser_top_tb;
   import plrp_pkg::*;

   localparam int RANDOM_ITEMS = 1850;
   localparam int IDLE_PCT     = 34;
   localparam int DRAIN_CYCLES = 4400;
   localparam longint CYCLE_LIMIT = 40000000;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic              found;
      logic              highest;
      logic [PORT_W-1:0] count;
      logic              err;
   } port_report_type;

   typedef struct packed {
      op_type          op;
      logic [7:0]      ch;
      logic            typed;
      port_report_type want;
   } stim_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   logic [MAP_WORD_BITS-1:0] map_words [MAP_WORDS];
   part_type        lo_part;
   part_type        hi_part;
   logic            dash_seen;
   logic            token_used;
   logic            sticky_err;
   int              fetch_from;
   int              unique_ports;
   port_report_type port_reports [$];
   logic [7:0]      entry_chars [$];
   stim_row_type    directed_rows [$];

   bit     calm         = 1'b0;
   int     mismatches   = 0;
   int     checked      = 0;
   int     fetched      = 0;
   int     err_reports  = 0;
   int     items_sent   = 0;
   longint cycle_count  = 0;

   port_list_range_parser_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void put_char(logic [7:0] c);
      entry_chars.insert(entry_chars.size(), c);
   endfunction

   function automatic void put_row(stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic void put_report(port_report_type r);
      port_reports.insert(port_reports.size(), r);
   endfunction

   function automatic void drop_token();
      lo_part    = '{PH_START, '0, 1'b0, 1'b0};
      hi_part    = lo_part;
      dash_seen  = 1'b0;
      token_used = 1'b0;
   endfunction

   function automatic void wipe_ports();
      foreach (map_words[i]) map_words[i] = '0;
      drop_token();
      fetch_from   = 0;
      unique_ports = 0;
      sticky_err   = 1'b0;
   endfunction

   function automatic void mark_ports(int a, int b);
      int lo;
      int hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (lo < 1) lo = 1;
      if (hi > int'(MAX_PORT)) hi = int'(MAX_PORT);
      for (int p = lo; p <= hi; p++) begin
         if (!map_words[p / MAP_WORD_BITS][p % MAP_WORD_BITS]) begin
            map_words[p / MAP_WORD_BITS][p % MAP_WORD_BITS] = 1'b1;
            unique_ports++;
         end
      end
   endfunction

   function automatic int next_port(int from);
      int p;
      p = (from < 1) ? 1 : from;
      while (p <= int'(MAX_PORT)) begin
         if ((map_words[p / MAP_WORD_BITS] >> (p % MAP_WORD_BITS)) == '0)
            p = (p / MAP_WORD_BITS + 1) * MAP_WORD_BITS;
         else if (map_words[p / MAP_WORD_BITS][p % MAP_WORD_BITS])
            return p;
         else
            p++;
      end
      return 0;
   endfunction

   function automatic void close_token();
      if (!lo_part.dig || (dash_seen && !hi_part.dig))
         sticky_err = 1'b1;
      else if (!dash_seen)
         mark_ports(int'(lo_part.val), int'(lo_part.val));
      else
         mark_ports(int'(lo_part.val), hi_part.neg ? 0 : int'(hi_part.val));
      drop_token();
   endfunction

   function automatic part_type feed_part(part_type cur, logic [7:0] c, logic allow_minus);
      part_type nxt;
      logic     take;
      int       v;
      nxt  = cur;
      take = 1'b0;
      case (cur.phase)
         PH_START: begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
               take = 1'b0;
            else if (c == CH_PLUS)
               nxt.phase = PH_SIGN;
            else if (c == CH_DASH && allow_minus) begin
               nxt.neg   = 1'b1;
               nxt.phase = PH_SIGN;
            end else
               take = 1'b1;
         end
         PH_SIGN, PH_DIGITS: take = 1'b1;
         default: take = 1'b0;
      endcase
      if (take) begin
         if (c >= CH_ZERO && c <= CH_NINE) begin
            v = cur.dig ? int'(cur.val) * 10 + int'(c - CH_ZERO) : int'(c - CH_ZERO);
            nxt.val   = (v > int'(VALUE_SAT)) ? VALUE_SAT : VALUE_W'(v);
            nxt.dig   = 1'b1;
            nxt.phase = PH_DIGITS;
         end else
            nxt.phase = PH_STOP;
      end
      return nxt;
   endfunction

   function automatic logic parse_step(op_type op, logic [7:0] c, output port_report_type rep);
      int p;
      rep = '0;
      case (op)
         OP_FEED: begin
            if (c == CH_COMMA)
               close_token();
            else begin
               token_used = 1'b1;
               if (!dash_seen && c == CH_DASH)
                  dash_seen = 1'b1;
               else if (!dash_seen)
                  lo_part = feed_part(lo_part, c, 1'b0);
               else
                  hi_part = feed_part(hi_part, c, 1'b1);
            end
            return 1'b0;
         end
         OP_CLEAR: begin
            wipe_ports();
            return 1'b0;
         end
         OP_END: begin
            if (token_used) close_token();
            drop_token();
            fetch_from = 0;
         end
         default: begin
            p = next_port(fetch_from);
            if (p != 0) begin
               fetch_from  = p + 1;
               rep.port    = PORT_W'(p);
               rep.found   = 1'b1;
               rep.highest = (next_port(p + 1) == 0);
            end
         end
      endcase
      rep.count = PORT_W'(unique_ports);
      rep.err   = sticky_err;
      return 1'b1;
   endfunction

   function automatic void add_part(logic high_side);
      int    v;
      string digits;
      if ($urandom_range(0, 99) < 15)
         put_char(($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
      if ($urandom_range(0, 99) < 15)
         put_char(CH_PLUS);
      else if (high_side && $urandom_range(0, 99) < 10)
         put_char(CH_DASH);
      if ($urandom_range(0, 99) < 6) begin
         if ($urandom_range(0, 1)) put_char(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 19))
            0: v = $urandom_range(0, 99999);
            1: v = $urandom_range(65530, 9999999);
            2: v = 0;
            default: v = $urandom_range(0, 600);
         endcase
         if ($urandom_range(0, 9) == 0) put_char(CH_ZERO);
         digits = $sformatf("%0d", v);
         for (int i = 0; i < digits.len(); i++) put_char(digits[i]);
      end
      if ($urandom_range(0, 9) == 0) put_char(8'($urandom_range(0, 255)));
   endfunction

   task automatic report_mismatch(string what, int got, int want_v);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want_v);
      mismatches++;
   endtask

   task automatic send_item(op_type op, logic [7:0] c, logic typed, port_report_type want);
      port_report_type rep;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (parse_step(op, c, rep)) put_report(typed ? want : rep);
      items_sent++;
   endtask

   always @(posedge clock) begin
      port_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (port_reports.size() == 0)
            report_mismatch("item with nothing pending, port", int'(rsp_tdata[15:0]), 0);
         else begin
            want = port_reports.pop_front();
            if (rsp_tdata[15:0] !== want.port)
               report_mismatch("port", int'(rsp_tdata[15:0]), int'(want.port));
            if (rsp_tuser !== want.found)
               report_mismatch("valid_res", int'(rsp_tuser), int'(want.found));
            if (rsp_tlast !== want.highest)
               report_mismatch("last_port", int'(rsp_tlast), int'(want.highest));
            if (rsp_tdata[31:16] !== want.count)
               report_mismatch("port_count", int'(rsp_tdata[31:16]), int'(want.count));
            if (rsp_tdata[32] !== want.err)
               report_mismatch("parse_error", int'(rsp_tdata[32]), int'(want.err));
            checked++;
            if (want.found) fetched++;
            if (want.err) err_reports++;
         end
      end
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d results pending", port_reports.size());
         $display("port_list_range_parser_top_tb: errors");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      int           n;
      int           kind;

      wipe_ports();
      put_row('{OP_FETCH, 8'h00, 1'b1, '{16'd0, 1'b0, 1'b0, 16'd0, 1'b0}});
      put_row('{OP_END, 8'hFF, 1'b1, '{16'd0, 1'b0, 1'b0, 16'd0, 1'b0}});
      put_row('{OP_FEED, CH_PLUS, 1'b0, '0});
      put_row('{OP_FEED, 8'h37, 1'b0, '0});
      repeat (4) put_row('{OP_FEED, CH_ZERO, 1'b0, '0});
      put_row('{OP_FEED, CH_DASH, 1'b0, '0});
      put_row('{OP_FEED, CH_ZERO, 1'b0, '0});
      put_row('{OP_END, 8'h00, 1'b1, '{16'd0, 1'b0, 1'b0, 16'd65535, 1'b0}});
      put_row('{OP_FETCH, 8'hAA, 1'b1, '{16'd1, 1'b1, 1'b0, 16'd65535, 1'b0}});
      put_row('{OP_CLEAR, 8'h55, 1'b0, '0});
      put_row('{OP_FEED, CH_COMMA, 1'b0, '0});
      put_row('{OP_FEED, CH_TAB, 1'b0, '0});
      put_row('{OP_FEED, 8'h33, 1'b0, '0});
      put_row('{OP_FEED, CH_DASH, 1'b0, '0});
      put_row('{OP_FEED, CH_DASH, 1'b0, '0});
      put_row('{OP_FEED, 8'h32, 1'b0, '0});
      put_row('{OP_FEED, 8'hFF, 1'b0, '0});
      put_row('{OP_FEED, CH_NINE, 1'b0, '0});
      put_row('{OP_END, 8'h00, 1'b1, '{16'd0, 1'b0, 1'b0, 16'd3, 1'b1}});
      put_row('{OP_FETCH, 8'h00, 1'b1, '{16'd1, 1'b1, 1'b0, 16'd3, 1'b1}});
      put_row('{OP_FETCH, 8'h00, 1'b0, '0});
      put_row('{OP_FETCH, 8'h00, 1'b1, '{16'd3, 1'b1, 1'b1, 16'd3, 1'b1}});
      put_row('{OP_FETCH, 8'h00, 1'b1, '{16'd0, 1'b0, 1'b0, 16'd3, 1'b1}});
      put_row('{OP_CLEAR, 8'h00, 1'b0, '0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_item(row.op, row.ch, row.typed, row.want);
      end

      while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
         calm = (items_sent > 800 && items_sent < 1100);
         if ($urandom_range(0, 4) == 0) send_item(OP_CLEAR, 8'($urandom), 1'b0, '0);
         entry_chars.delete();
         n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
         for (int t = 0; t < n; t++) begin
            if (t != 0) put_char(CH_COMMA);
            kind = $urandom_range(0, 99);
            if (kind >= 6 && kind < 12)
               repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(0, 255)));
            else if (kind >= 12) begin
               add_part(1'b0);
               if (kind < 45) begin
                  put_char(CH_DASH);
                  add_part(1'b1);
               end
            end
         end
         if ($urandom_range(0, 9) == 0) put_char(CH_COMMA);
         foreach (entry_chars[i]) begin
            if ($urandom_range(0, 59) == 0)
               send_item(op_type'($urandom_range(int'(OP_END), int'(OP_CLEAR))),
                         8'($urandom), 1'b0, '0);
            send_item(OP_FEED, entry_chars[i], 1'b0, '0);
         end
         send_item(OP_END, 8'($urandom), 1'b0, '0);
         if ($urandom_range(0, 2) != 0)
            repeat ($urandom_range(1, 6)) send_item(OP_FETCH, 8'($urandom), 1'b0, '0);
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      while (port_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d items (%0d from the directed table), checked %0d results",
               items_sent, directed_rows.size(), checked);
      $display("%0d ports fetched, %0d results carried the sticky error flag",
               fetched, err_reports);
      if (mismatches == 0)
         $display("port_list_range_parser_top_tb: clean");
      else
         $display("port_list_range_parser_top_tb: errors");
      $finish;
   end

endmodule

// File: files.f
hdl/plrp_pkg.sv
hdl/plrp_parse.sv
hdl/port_list_range_parser_top.sv
tb/port_list_range_parser_top_tb.sv
